/* hw/rtl/skt_pkg.sv */
// Shared types, codes and constants for the sorted key table.
`timescale 1ns / 1ps
package skt_pkg;

  localparam int CAPACITY    = 16;
  localparam int MAX_RESULTS = 16;

  localparam int REQ_W   = 2;
  localparam int ID_W    = 16;
  localparam int QTY_W   = 16;
  localparam int PRICE_W = 24;
  localparam int STAT_W  = 2;
  localparam int POS_W   = 4;

  typedef enum logic [REQ_W-1:0] {
    REQ_FIND   = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_LIST   = 2'd3
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_LIST
  } state_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INS,
    OP_DEL,
    OP_ROT
  } cell_op_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [QTY_W-1:0]   qty;
    logic [PRICE_W-1:0] price;
  } rec_t;

  typedef struct packed {
    cell_op_t op;
    logic     valid;
    logic     valid_next;
  } cell_cmd_t;

  typedef struct packed {
    logic mark;
    logic seen;
    logic ins_hit;
    logic hit;
  } cell_stat_t;

endpackage

/* hw/rtl/skt_in_if.sv */
// Request channel interface: valid, ready and the request fields.
`timescale 1ns / 1ps
interface skt_in_if;
  logic                        valid;
  logic                        ready;
  logic [skt_pkg::REQ_W-1:0]   req_type;
  logic [skt_pkg::ID_W-1:0]    key_id;
  logic [skt_pkg::QTY_W-1:0]   new_quantity;
  logic [skt_pkg::PRICE_W-1:0] new_price;

  modport source (
    output valid, req_type, key_id, new_quantity, new_price,
    input  ready
  );
  modport sink (
    input  valid, req_type, key_id, new_quantity, new_price,
    output ready
  );
endinterface

/* hw/rtl/skt_out_if.sv */
// Result channel interface: valid, ready and the result fields.
`timescale 1ns / 1ps
interface skt_out_if;
  logic                        valid;
  logic                        ready;
  logic [skt_pkg::STAT_W-1:0]  status;
  logic [skt_pkg::POS_W-1:0]   position;
  logic [skt_pkg::ID_W-1:0]    rec_id;
  logic [skt_pkg::QTY_W-1:0]   rec_quantity;
  logic [skt_pkg::PRICE_W-1:0] rec_price;
  logic                        last;

  modport source (
    output valid, status, position, rec_id, rec_quantity, rec_price, last,
    input  ready
  );
  modport sink (
    input  valid, status, position, rec_id, rec_quantity, rec_price, last,
    output ready
  );
endinterface

/* hw/rtl/skt_cell.sv */
// One table slot: holds a record, compares it with the key, shifts with its neighbours.
`timescale 1ns / 1ps
module skt_cell (
  input  logic                       clk,
  input  logic                       cmp_en,
  input  logic [skt_pkg::ID_W-1:0]   key,
  input  skt_pkg::cell_cmd_t         cmd,
  input  skt_pkg::rec_t              new_rec,
  input  skt_pkg::rec_t              prev_rec,
  input  skt_pkg::rec_t              next_rec,
  input  skt_pkg::rec_t              head_rec,
  input  skt_pkg::cell_stat_t        prev_stat,
  output skt_pkg::rec_t              rec,
  output skt_pkg::cell_stat_t        stat
);

  skt_pkg::rec_t rec_r;
  skt_pkg::rec_t rec_nxt;
  logic          ge_r;
  logic          eq_r;
  logic          match;

  assign rec          = rec_r;
  assign match        = cmd.valid && eq_r;
  assign stat.mark    = !cmd.valid || ge_r;
  assign stat.seen    = prev_stat.seen || match;
  assign stat.ins_hit = stat.mark && !prev_stat.mark;
  assign stat.hit     = match && !prev_stat.seen;

  always_comb begin
    rec_nxt = rec_r;
    case (cmd.op)
      skt_pkg::OP_INS: begin
        if (stat.ins_hit) begin
          rec_nxt = new_rec;
        end else if (prev_stat.mark) begin
          rec_nxt = prev_rec;
        end
      end
      skt_pkg::OP_DEL: begin
        if (stat.seen) begin
          rec_nxt = next_rec;
        end
      end
      skt_pkg::OP_ROT: begin
        if (cmd.valid) begin
          rec_nxt = cmd.valid_next ? next_rec : head_rec;
        end
      end
      default: rec_nxt = rec_r;
    endcase
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
    if (cmp_en) begin
      ge_r <= (rec_r.id >= key);
      eq_r <= (rec_r.id == key);
    end
  end

endmodule

/* hw/rtl/sorted_key_table_unit.sv */
// Top level of the sorted key table: cell row, request sequencer and result register.
//
// Requests arrive on in_ch (find, insert, delete, list) and results leave on
// out_ch; both are valid/ready channels and an item moves when both are high.
// Every cell compares its record with the key in the cycle the request is
// taken and registers the outcome; the evaluate state then, once the result
// register is free, shifts the row for an insert or delete and loads the
// result register for a find, insert or delete; the next request waits for it.
// A list rotates the row one step a cycle through its head cell, emitting one
// entry per step for the first 16 entries, a step waiting while the result
// register is held, and rotating the rest silently.
// The result register holds its item while out_ch.ready is low; one more
// request may be taken meanwhile, and that request and the row then hold
// until the register frees.
// Reset empties the table (entry count to zero) and clears the result valid;
// the stored records are left as they are and are never read until written.
// Insert on a full table answers full; find, delete or list on an empty table
// answers a single empty result.
`timescale 1ns / 1ps
module sorted_key_table_unit #(
  parameter int CAPACITY = skt_pkg::CAPACITY
) (
  input logic         clk,
  input logic         rst_n,
  skt_in_if.sink      in_ch,
  skt_out_if.source   out_ch
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = (CW > 5) ? CW : 5;

  skt_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   k_r, k_nxt;
  skt_pkg::req_t   req_r;
  skt_pkg::rec_t   new_rec_r;
  skt_pkg::cell_op_t op;

  logic                          out_valid_r;
  logic [skt_pkg::STAT_W-1:0]    out_status_r;
  logic [skt_pkg::POS_W-1:0]     out_pos_r;
  skt_pkg::rec_t                 out_rec_r;
  logic                          out_last_r;

  logic                          emit;
  skt_pkg::status_t              emit_status;
  logic [skt_pkg::POS_W-1:0]     emit_pos;
  skt_pkg::rec_t                 emit_rec;
  logic                          emit_last;

  logic          accept;
  logic          out_free;
  skt_pkg::rec_t recs [CAPACITY];
  skt_pkg::cell_stat_t stats [CAPACITY];
  skt_pkg::cell_cmd_t  cmds  [CAPACITY];

  logic [LW-1:0] ins_pos;
  logic [LW-1:0] hit_pos;
  skt_pkg::rec_t hit_rec;
  logic          any_hit;
  logic [LW-1:0] k_ext;
  logic [LW-1:0] list_n;
  logic [LW-1:0] count_ext;

  assign in_ch.ready = (state_r == skt_pkg::ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.position     = out_pos_r;
  assign out_ch.rec_id       = out_rec_r.id;
  assign out_ch.rec_quantity = out_rec_r.qty;
  assign out_ch.rec_price    = out_rec_r.price;
  assign out_ch.last         = out_last_r;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    skt_pkg::cell_stat_t prev_stat;
    skt_pkg::rec_t       prev_rec;
    skt_pkg::rec_t       next_rec;

    if (i == 0) begin : g_first
      assign prev_stat = '0;
      assign prev_rec  = new_rec_r;
    end else begin : g_mid
      assign prev_stat = stats[i-1];
      assign prev_rec  = recs[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign next_rec = recs[i];
    end else begin : g_body
      assign next_rec = recs[i+1];
    end

    assign cmds[i].op         = op;
    assign cmds[i].valid      = (CW'(i) < count_r);
    assign cmds[i].valid_next = (CW'(i + 1) < count_r);

    skt_cell u_cell (
      .clk       (clk),
      .cmp_en    (accept),
      .key       (in_ch.key_id),
      .cmd       (cmds[i]),
      .new_rec   (new_rec_r),
      .prev_rec  (prev_rec),
      .next_rec  (next_rec),
      .head_rec  (recs[0]),
      .prev_stat (prev_stat),
      .rec       (recs[i]),
      .stat      (stats[i])
    );
  end

  always_comb begin
    ins_pos = '0;
    hit_pos = '0;
    hit_rec = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (stats[i].ins_hit) ins_pos = ins_pos | LW'(i);
      if (stats[i].hit) begin
        hit_pos = hit_pos | LW'(i);
        hit_rec = hit_rec | recs[i];
      end
    end
  end

  assign any_hit   = stats[CAPACITY-1].seen;
  assign k_ext     = LW'(k_r);
  assign count_ext = LW'(count_r);
  assign list_n    = (count_ext < LW'(skt_pkg::MAX_RESULTS)) ? count_ext
                                                             : LW'(skt_pkg::MAX_RESULTS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= skt_pkg::ST_IDLE;
      count_r     <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      k_r     <= k_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r           <= skt_pkg::req_t'(in_ch.req_type);
      new_rec_r.id    <= in_ch.key_id;
      new_rec_r.qty   <= in_ch.new_quantity;
      new_rec_r.price <= in_ch.new_price;
    end
    if (emit) begin
      out_status_r <= emit_status;
      out_pos_r    <= emit_pos;
      out_rec_r    <= emit_rec;
      out_last_r   <= emit_last;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    k_nxt       = k_r;
    op          = skt_pkg::OP_HOLD;
    emit        = 1'b0;
    emit_status = skt_pkg::STAT_OK;
    emit_pos    = '0;
    emit_rec    = '0;
    emit_last   = 1'b1;
    unique case (state_r)
      skt_pkg::ST_IDLE: begin
        if (accept) state_nxt = skt_pkg::ST_EVAL;
      end
      skt_pkg::ST_EVAL: begin
        if (out_free) begin
          state_nxt = skt_pkg::ST_IDLE;
          if (req_r == skt_pkg::REQ_INSERT) begin
            emit = 1'b1;
            if (count_r == CW'(CAPACITY)) begin
              emit_status = skt_pkg::STAT_FULL;
            end else begin
              op        = skt_pkg::OP_INS;
              emit_pos  = ins_pos[skt_pkg::POS_W-1:0];
              emit_rec  = new_rec_r;
              count_nxt = count_r + CW'(1);
            end
          end else if (count_r == '0) begin
            emit        = 1'b1;
            emit_status = skt_pkg::STAT_EMPTY;
          end else if (req_r == skt_pkg::REQ_LIST) begin
            state_nxt = skt_pkg::ST_LIST;
            k_nxt     = '0;
          end else if (!any_hit) begin
            emit        = 1'b1;
            emit_status = skt_pkg::STAT_NOT_FOUND;
          end else begin
            emit     = 1'b1;
            emit_pos = hit_pos[skt_pkg::POS_W-1:0];
            emit_rec = hit_rec;
            if (req_r == skt_pkg::REQ_DELETE) begin
              op        = skt_pkg::OP_DEL;
              count_nxt = count_r - CW'(1);
            end
          end
        end
      end
      skt_pkg::ST_LIST: begin
        if (k_ext >= list_n || out_free) begin
          op        = skt_pkg::OP_ROT;
          emit      = (k_ext < list_n);
          emit_pos  = k_ext[skt_pkg::POS_W-1:0];
          emit_rec  = recs[0];
          emit_last = (k_ext + LW'(1) == list_n);
          k_nxt     = k_r + CW'(1);
          if (k_r == count_r - CW'(1)) state_nxt = skt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = skt_pkg::ST_IDLE;
    endcase
  end

endmodule

/* verif/sorted_key_table_unit_test.sv */
// Self-checking testbench for the sorted key table: directed and random requests.
`timescale 1ns / 1ps
module sorted_key_table_unit_test;

  localparam int CYCLE_LIMIT  = 2000000;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_MAX   = 10;

  typedef logic [skt_pkg::ID_W-1:0]    id_t;
  typedef logic [skt_pkg::QTY_W-1:0]   qty_t;
  typedef logic [skt_pkg::PRICE_W-1:0] price_t;

  typedef struct packed {
    skt_pkg::status_t           status;
    logic [skt_pkg::POS_W-1:0]  position;
    skt_pkg::rec_t              rec;
    logic                       last;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n;

  skt_in_if  in_ch ();
  skt_out_if out_ch ();

  sorted_key_table_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  skt_pkg::rec_t rows[$];
  reply_t        awaited_replies[$];

  bit idle_on;
  int sink_hold;
  int mismatches;
  int items_sent;
  int replies_checked;
  int full_seen;
  int empty_seen;
  int miss_seen;
  int list_longest;

  function automatic int idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 20);
  endfunction

  function automatic id_t pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (rows.size() > 0 && r < 5) return rows[$urandom_range(0, rows.size() - 1)].id;
    if (r < 8) return id_t'($urandom_range(0, 23));
    if (r == 8) return $urandom_range(0, 1) ? '0 : '1;
    return id_t'($urandom_range(0, 65535));
  endfunction

  function automatic void predict_replies(input skt_pkg::req_t rq, input id_t key,
                                          input qty_t qty, input price_t price);
    reply_t        r;
    skt_pkg::rec_t row;
    int            p;
    int            n;
    r = '0;
    r.status = skt_pkg::STAT_OK;
    r.last = 1'b1;
    if (rq == skt_pkg::REQ_INSERT) begin
      if (rows.size() >= skt_pkg::CAPACITY) begin
        r.status = skt_pkg::STAT_FULL;
        full_seen++;
      end else begin
        p = 0;
        while (p < rows.size() && rows[p].id < key) p++;
        row.id = key;
        row.qty = qty;
        row.price = price;
        rows.insert(p, row);
        r.position = p[skt_pkg::POS_W-1:0];
        r.rec = row;
      end
      awaited_replies.push_back(r);
    end else if (rows.size() == 0) begin
      r.status = skt_pkg::STAT_EMPTY;
      empty_seen++;
      awaited_replies.push_back(r);
    end else if (rq == skt_pkg::REQ_LIST) begin
      n = (rows.size() < skt_pkg::MAX_RESULTS) ? rows.size() : skt_pkg::MAX_RESULTS;
      if (n > list_longest) list_longest = n;
      for (int i = 0; i < n; i++) begin
        r.position = i[skt_pkg::POS_W-1:0];
        r.rec = rows[i];
        r.last = (i == n - 1);
        awaited_replies.push_back(r);
      end
    end else begin
      p = 0;
      while (p < rows.size() && rows[p].id != key) p++;
      if (p == rows.size()) begin
        r.status = skt_pkg::STAT_NOT_FOUND;
        miss_seen++;
      end else begin
        r.position = p[skt_pkg::POS_W-1:0];
        r.rec = rows[p];
        if (rq == skt_pkg::REQ_DELETE) rows.delete(p);
      end
      awaited_replies.push_back(r);
    end
  endfunction

  task automatic send_item(input skt_pkg::req_t rq, input id_t key,
                           input qty_t qty, input price_t price);
    int gap;
    gap = (idle_on && $urandom_range(0, 1) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.req_type <= rq;
    in_ch.key_id <= key;
    in_ch.new_quantity <= qty;
    in_ch.new_price <= price;
    do @(posedge clk); while (!in_ch.ready);
    predict_replies(rq, key, qty, price);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_items(input int n, input int w_ins, input int w_del, input int w_find);
    int            pick;
    skt_pkg::req_t rq;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < w_ins) rq = skt_pkg::REQ_INSERT;
      else if (pick < w_ins + w_del) rq = skt_pkg::REQ_DELETE;
      else if (pick < w_ins + w_del + w_find) rq = skt_pkg::REQ_FIND;
      else rq = skt_pkg::REQ_LIST;
      send_item(rq, pick_key(), qty_t'($urandom_range(0, 65535)),
                price_t'($urandom_range(0, 24'hFFFFFF)));
    end
  endtask

  task automatic test_empty_table();
    send_item(skt_pkg::REQ_FIND, '1, '1, '1);
    send_item(skt_pkg::REQ_DELETE, '0, '0, '0);
    send_item(skt_pkg::REQ_LIST, 16'h5A5A, 16'hA5A5, 24'h5A5A5A);
  endtask

  task automatic test_fill_and_full();
    send_item(skt_pkg::REQ_INSERT, 16'd0, 16'hFFFF, 24'hFFFFFF);
    send_item(skt_pkg::REQ_INSERT, 16'hFFFF, 16'h0000, 24'h000000);
    send_item(skt_pkg::REQ_INSERT, 16'd100, 16'd1, 24'd1);
    send_item(skt_pkg::REQ_INSERT, 16'd100, 16'd2, 24'd2);
    send_item(skt_pkg::REQ_INSERT, 16'd100, 16'd3, 24'd3);
    send_item(skt_pkg::REQ_INSERT, 16'd7, 16'h8000, 24'h800000);
    send_item(skt_pkg::REQ_INSERT, 16'hFFFF, 16'h7FFF, 24'h7FFFFF);
    send_item(skt_pkg::REQ_INSERT, 16'd8, 16'h5555, 24'h555555);
    send_item(skt_pkg::REQ_INSERT, 16'd1, 16'hAAAA, 24'hAAAAAA);
    send_item(skt_pkg::REQ_INSERT, 16'd200, 16'd20, 24'd200);
    send_item(skt_pkg::REQ_INSERT, 16'd50, 16'd5, 24'd50);
    send_item(skt_pkg::REQ_INSERT, 16'd50, 16'd6, 24'd51);
    send_item(skt_pkg::REQ_INSERT, 16'd3, 16'd33, 24'd333);
    send_item(skt_pkg::REQ_INSERT, 16'd30000, 16'd300, 24'd30000);
    send_item(skt_pkg::REQ_INSERT, 16'd12345, 16'd123, 24'd12345);
    send_item(skt_pkg::REQ_INSERT, 16'd2, 16'd22, 24'd222);
    send_item(skt_pkg::REQ_INSERT, 16'd5, 16'd55, 24'd555);
    send_item(skt_pkg::REQ_LIST, '0, '0, '0);
    send_item(skt_pkg::REQ_FIND, 16'd100, '0, '0);
    send_item(skt_pkg::REQ_FIND, 16'd9, '1, '1);
    send_item(skt_pkg::REQ_DELETE, 16'd9, '0, '0);
    send_item(skt_pkg::REQ_DELETE, 16'hFFFF, '0, '0);
  endtask

  task automatic test_backpressure();
    idle_on = 1'b0;
    sink_hold = 160;
    random_items(24, 30, 25, 25);
    wait_drained();
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    random_items(60, 35, 30, 25);
    wait_drained();
  endtask

  task automatic test_grow_shrink();
    idle_on = 1'b1;
    repeat (3) begin
      random_items(45, 70, 10, 10);
      wait_drained();
      random_items(45, 10, 70, 10);
      wait_drained();
    end
  endtask

  task automatic test_mixed();
    idle_on = 1'b1;
    random_items(45, 35, 30, 25);
    wait_drained();
  endtask

  initial begin : result_sink
    int n;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold > 0) begin
        out_ch.ready <= 1'b0;
        n = sink_hold;
        sink_hold = 0;
        repeat (n) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat (idle_len()) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : reply_check
    reply_t got;
    reply_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.status = skt_pkg::status_t'(out_ch.status);
      got.position = out_ch.position;
      got.rec.id = out_ch.rec_id;
      got.rec.qty = out_ch.rec_quantity;
      got.rec.price = out_ch.rec_price;
      got.last = out_ch.last;
      if (awaited_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected reply: st=%0d pos=%0d id=%h qty=%h price=%h last=%b",
                   got.status, got.position, got.rec.id, got.rec.qty, got.rec.price,
                   got.last);
      end else begin
        want = awaited_replies.pop_front();
        replies_checked++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("reply %0d mismatch: exp st=%0d pos=%0d id=%h qty=%h price=%h last=%b",
                     replies_checked, want.status, want.position, want.rec.id,
                     want.rec.qty, want.rec.price, want.last);
            $display("                    got st=%0d pos=%0d id=%h qty=%h price=%h last=%b",
                     got.status, got.position, got.rec.id, got.rec.qty,
                     got.rec.price, got.last);
          end
        end
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.req_type <= skt_pkg::REQ_FIND;
    in_ch.key_id <= '0;
    in_ch.new_quantity <= '0;
    in_ch.new_price <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    test_fill_and_full();
    wait_drained();
    test_backpressure();
    test_steady_stream();
    test_grow_shrink();
    test_mixed();
    wait_drained();
    $display("%0d requests sent, %0d replies checked, %0d mismatches",
             items_sent, replies_checked, mismatches);
    $display("full refusals %0d, empty answers %0d, misses %0d, longest listing %0d",
             full_seen, empty_seen, miss_seen, list_longest);
    if (mismatches == 0 && awaited_replies.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
